@@ hw/rtl/wavw_pkg.sv @@
`default_nettype none
package wavw_pkg;

  localparam int unsigned CmdWidth = 1;
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam int unsigned HdrLen = 44;
  localparam logic [31:0] DEFAULT_RATE = 32'd44100;
  localparam logic [15:0] DEFAULT_CHANNELS = 16'd1;
  localparam logic [31:0] RIFF_BASE = 32'd36;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_RATE = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [31:0] sample_bits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_word_t;

  // Header fields after the products, ready for byte selection.
  typedef struct packed {
    logic [15:0] ch;
    logic [31:0] rate;
    logic [31:0] data_size;
    logic [31:0] byte_rate;
  } hdr_fields_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] pcm;
    hdr_fields_t hdr;
  } job_t;

  function automatic logic [7:0] hdr_byte(input hdr_fields_t h, input logic [5:0] idx);
    logic [31:0] riff;
    logic [15:0] align;
    logic [7:0]  b;
    riff  = RIFF_BASE + h.data_size;
    align = {h.ch[14:0], 1'b0};
    case (idx)
      6'd0: b = 8'h52;  6'd1: b = 8'h49;  6'd2: b = 8'h46;  6'd3: b = 8'h46;
      6'd4: b = riff[7:0];   6'd5: b = riff[15:8];
      6'd6: b = riff[23:16]; 6'd7: b = riff[31:24];
      6'd8: b = 8'h57;  6'd9: b = 8'h41;  6'd10: b = 8'h56; 6'd11: b = 8'h45;
      6'd12: b = 8'h66; 6'd13: b = 8'h6d; 6'd14: b = 8'h74; 6'd15: b = 8'h20;
      6'd16: b = 8'd16; 6'd17: b = 8'h00; 6'd18: b = 8'h00; 6'd19: b = 8'h00;
      6'd20: b = 8'd1;  6'd21: b = 8'h00;
      6'd22: b = h.ch[7:0];    6'd23: b = h.ch[15:8];
      6'd24: b = h.rate[7:0];  6'd25: b = h.rate[15:8];
      6'd26: b = h.rate[23:16]; 6'd27: b = h.rate[31:24];
      6'd28: b = h.byte_rate[7:0];   6'd29: b = h.byte_rate[15:8];
      6'd30: b = h.byte_rate[23:16]; 6'd31: b = h.byte_rate[31:24];
      6'd32: b = align[7:0]; 6'd33: b = align[15:8];
      6'd34: b = 8'd16; 6'd35: b = 8'h00;
      6'd36: b = 8'h64; 6'd37: b = 8'h61; 6'd38: b = 8'h74; 6'd39: b = 8'h61;
      6'd40: b = h.data_size[7:0];   6'd41: b = h.data_size[15:8];
      6'd42: b = h.data_size[23:16]; 6'd43: b = h.data_size[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/wav_pcm16_stream_writer.sv @@
`default_nettype none
// WAV PCM16 byte stream writer. A header word (cmd 0) yields the 44-byte
// RIFF/WAVE header built from the channel, rate and frame registers; a sample
// word (cmd 1) yields two little-endian bytes of the converted binary32
// sample. A word passes the converter stages, the serializer's job register
// and its output register before its first byte is valid, then one byte per
// cycle while the receiver is ready: 2 per sample, 44 per header. Input words
// are taken while bytes still drain, unless the converter's last stage is held.
// Registers: 0x0 channel_count, 0x4 sample_rate, 0x8 frame_count.
module wav_pcm16_stream_writer
  import wavw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] frame_count;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= DEFAULT_CHANNELS;
      sample_rate   <= DEFAULT_RATE;
      frame_count   <= 32'd0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_CHANNELS: channel_count <= pwdata[15:0];
        REG_RATE:     sample_rate <= pwdata;
        REG_FRAMES:   frame_count <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNELS: prdata = {16'd0, channel_count};
      REG_RATE:     prdata = sample_rate;
      REG_FRAMES:   prdata = frame_count;
      default:      prdata = 32'd0;
    endcase
  end

  logic job_valid;
  logic job_ready;
  job_t job;
  logic advance;

  // advance the pipe unless its last stage is full and blocked
  assign advance  = !job_valid || job_ready;
  assign in_ready = advance;

  wavw_conv u_conv (
    .clk, .rst, .advance,
    .in_valid(in_valid),
    .in_word(in_data),
    .ch_cfg(channel_count),
    .rate_cfg(sample_rate),
    .frames_cfg(frame_count),
    .out_valid(job_valid),
    .out_job(job)
  );

  wavw_ser u_ser (
    .clk, .rst,
    .job_valid, .job, .job_ready,
    .out_valid, .out_ready,
    .out_word(out_data)
  );

endmodule
`default_nettype wire

@@ hw/rtl/wavw_conv.sv @@
`default_nettype none
// Three-stage binary32 to PCM16 converter with a header-size path alongside.
// Stage 1: clamp, select scale, 24x16 product. Stage 2: round product to
// binary32 (24 bits). Stage 3: round half away to integer, header products.
module wavw_conv
  import wavw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        in_valid,
  input  wire in_word_t    in_word,
  input  wire logic [15:0] ch_cfg,
  input  wire logic [31:0] rate_cfg,
  input  wire logic [31:0] frames_cfg,
  output logic             out_valid,
  output job_t             out_job
);

  // stage 1
  logic        s1_valid;
  logic        s1_cmd;
  logic        s1_zero;
  logic        s1_neg;
  logic [39:0] s1_prod;
  logic [7:0]  s1_exp;
  logic [15:0] s1_ch;
  logic [31:0] s1_rate;
  logic [31:0] s1_frames2;

  logic [7:0]  e_in;
  logic [23:0] m_in;
  logic        n_in;
  logic        big;
  logic [23:0] m_c;
  logic [7:0]  e_c;
  logic [15:0] scale;
  logic [15:0] ch_eff;

  always_comb begin
    e_in  = in_word.sample_bits[30:23];
    n_in  = in_word.sample_bits[31];
    m_in  = {(e_in != 8'd0), in_word.sample_bits[22:0]};
    big   = (e_in >= 8'd127);
    m_c   = big ? 24'h800000 : m_in;
    e_c   = big ? 8'd127 : ((e_in == 8'd0) ? 8'd1 : e_in);
    scale = (n_in && (m_in != 24'd0)) ? 16'd32768 : 16'd32767;
    ch_eff = (ch_cfg == 16'd0) ? DEFAULT_CHANNELS : ch_cfg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
    if (advance) begin
      s1_cmd  <= in_word.cmd;
      s1_zero <= (e_in == 8'hff) || (m_in == 24'd0) || (e_c < 8'd102);
      s1_neg  <= n_in;
      s1_prod <= {16'd0, m_c} * {24'd0, scale};
      s1_exp  <= e_c;
      s1_ch   <= ch_eff;
      s1_rate <= (rate_cfg == 32'd0) ? DEFAULT_RATE : rate_cfg;
      s1_frames2 <= {frames_cfg[30:0], 1'b0};
    end
  end

  // stage 2: normalize to 24 significant bits with round to nearest even
  logic        s2_valid;
  logic        s2_cmd;
  logic        s2_zero;
  logic        s2_neg;
  logic [24:0] s2_sig;
  logic [7:0]  s2_exp;
  logic [15:0] s2_ch;
  logic [31:0] s2_rate;
  logic [31:0] s2_frames2;

  logic [23:0] keep;
  logic        g;
  logic        st;
  logic        top;

  // leading one of the product sits at bit 38 or bit 37
  always_comb begin
    top = s1_prod[38];
    if (top) begin
      keep = s1_prod[38:15];
      g    = s1_prod[14];
      st   = |s1_prod[13:0];
    end else begin
      keep = s1_prod[37:14];
      g    = s1_prod[13];
      st   = |s1_prod[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_cmd  <= s1_cmd;
      s2_zero <= s1_zero;
      s2_neg  <= s1_neg;
      s2_sig  <= {1'b0, keep} + {24'd0, g & (st | keep[0])};
      s2_exp  <= s1_exp + {7'd0, top};
      s2_ch   <= s1_ch;
      s2_rate <= s1_rate;
      s2_frames2 <= s1_frames2;
    end
  end

  // stage 3: value = sig * 2^(exp-136); integer part via shift
  logic [47:0] fix;
  logic [5:0]  sh;
  logic [16:0] mag;
  logic        half;
  logic [15:0] pcm;
  logic [31:0] rate_x2;

  always_comb begin
    // integer = sig >> (136 - exp); exp ranges 102..128 here unless s2_zero is set
    fix  = {s2_sig, 23'd0};
    sh   = 6'(8'd136 - s2_exp);
    fix  = fix >> sh;
    mag  = fix[39:23];
    half = fix[22];
    mag  = mag + {16'd0, half};
    pcm  = s2_zero ? 16'd0 : (s2_neg ? 16'(-mag) : mag[15:0]);
    rate_x2 = {s2_rate[30:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
    if (advance) begin
      out_job.cmd <= s2_cmd;
      out_job.pcm <= pcm;
      out_job.hdr.ch <= s2_ch;
      out_job.hdr.rate <= s2_rate;
      out_job.hdr.data_size <= s2_frames2 * {16'd0, s2_ch};
      out_job.hdr.byte_rate <= rate_x2 * {16'd0, s2_ch};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/wavw_ser.sv @@
`default_nettype none
// Byte serializer: takes one job, emits 2 or 44 bytes through an output register.
module wavw_ser
  import wavw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      job_valid,
  input  wire job_t      job,
  output logic           job_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  logic        busy;
  job_t        cur;
  logic [5:0]  idx;
  logic [5:0]  last_idx;
  logic        emit;
  logic        out_free;
  logic [7:0]  b;

  assign last_idx = (cur.cmd == CMD_SAMPLE) ? 6'd1 : 6'(HdrLen - 1);
  assign out_free = !out_valid || out_ready;
  assign emit     = busy && out_free;
  assign job_ready = !busy || (emit && (idx == last_idx));

  always_comb begin
    if (cur.cmd == CMD_SAMPLE) begin
      b = idx[0] ? cur.pcm[15:8] : cur.pcm[7:0];
    end else begin
      b = hdr_byte(cur.hdr, idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= 6'd0;
    end else begin
      if (out_free) begin
        out_valid <= emit;
      end
      if (job_ready) begin
        busy <= job_valid;
        idx  <= 6'd0;
      end else if (emit) begin
        idx <= idx + 6'd1;
      end
    end
    if (job_ready && job_valid) begin
      cur <= job;
    end
    if (emit) begin
      out_word.out_byte  <= b;
      out_word.last_byte <= (idx == last_idx);
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= last_idx) else $error("byte index past end");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (emit && idx == last_idx) |-> job_ready) else $error("last byte did not free job");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_word)) else $error("output changed");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import wavw_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wav_pcm16_stream_writer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers.
  logic [15:0] chan_reg = DEFAULT_CHANNELS;
  logic [31:0] rate_reg = DEFAULT_RATE;
  logic [31:0] frames_reg = '0;

  in_word_t  word_queue[$];
  out_word_t byte_queue[$];
  int mismatches = 0;
  int bytes_seen = 0;
  int headers_sent = 0;
  int samples_sent = 0;

  // Exact integer form: scale, round to 24 bits, then round half away.
  function automatic logic [15:0] float_to_pcm(input logic [31:0] bits);
    int e;
    int lead;
    int drop;
    int sh;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] kept;
    logic [63:0] mag;
    logic g;
    logic st;
    if (bits[30:23] == 8'hFF) return 16'h0000;
    e = int'(bits[30:23]);
    m = {40'd0, (bits[30:23] != 8'd0), bits[22:0]};
    if (m == 64'd0) return 16'h0000;
    if (e == 0) e = 1;
    // clamp magnitude to one
    if (e >= 127) begin
      m = 64'h800000;
      e = 127;
    end
    p = m * (bits[31] ? 64'd32768 : 64'd32767);
    lead = 63;
    while (!p[lead]) lead--;
    drop = lead - 23;
    if (drop > 0) begin
      kept = p >> drop;
      g = p[drop - 1];
      st = (p & ((64'd1 << (drop - 1)) - 64'd1)) != 64'd0;
      kept = kept + {63'd0, g & (st | kept[0])};
      p = kept << drop;
    end
    sh = 150 - e;
    if (sh > 62) begin
      mag = 64'd0;
    end else begin
      mag = p >> sh;
      if (p[sh - 1]) mag = mag + 64'd1;
    end
    return bits[31] ? 16'(64'd0 - mag) : mag[15:0];
  endfunction

  task automatic push_bytes(input logic [31:0] v, input int n, input bit fin);
    for (int k = 0; k < n; k++)
      byte_queue.insert(byte_queue.size(),
                        '{out_byte: v[8*k +: 8], last_byte: fin && (k == n - 1)});
  endtask

  task automatic predict_word(input in_word_t w);
    logic [31:0] ch;
    logic [31:0] rt;
    logic [31:0] dsize;
    ch = (chan_reg == 0) ? 32'd1 : {16'd0, chan_reg};
    rt = (rate_reg == 0) ? DEFAULT_RATE : rate_reg;
    dsize = frames_reg * ch * 32'd2;
    if (w.cmd == CMD_HEADER) begin
      push_bytes(32'h46464952, 4, 0);
      push_bytes(RIFF_BASE + dsize, 4, 0);
      push_bytes(32'h45564157, 4, 0);
      push_bytes(32'h20746d66, 4, 0);
      push_bytes(32'd16, 4, 0);
      push_bytes(32'd1, 2, 0);
      push_bytes(ch, 2, 0);
      push_bytes(rt, 4, 0);
      push_bytes(rt * ch * 32'd2, 4, 0);
      push_bytes(ch * 32'd2, 2, 0);
      push_bytes(32'd16, 2, 0);
      push_bytes(32'h61746164, 4, 0);
      push_bytes(dsize, 4, 1);
    end else begin
      push_bytes({16'd0, float_to_pcm(w.sample_bits)}, 2, 1);
    end
  endtask

  // Acceptance seen at the last rising edge.
  logic in_ready_seen = 1'b0;

  // Driver: bursts with random gaps.
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (gap_left > 0 || word_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_data <= word_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 0);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      predict_word(in_data);
      if (in_data.cmd == CMD_HEADER) headers_sent++;
      else samples_sent++;
    end
  end

  // Receiver stall pattern.
  int stall_phase = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 200 == 0) stall_mode <= $urandom_range(3, 0);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(3, 0) != 0);
      2: out_ready <= (stall_phase % 7) < 3;
      default: out_ready <= $urandom_range(1, 0);
    endcase
  end

  // Monitor.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      bytes_seen++;
      if (byte_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %h last %b", out_data.out_byte,
                                       out_data.last_byte);
      end else begin
        exp_w = byte_queue.pop_front();
        if (exp_w !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte %0d: expected %h/%b got %h/%b", bytes_seen, exp_w.out_byte,
                     exp_w.last_byte, out_data.out_byte, out_data.last_byte);
        end
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CHANNELS: chan_reg = val[15:0];
      REG_RATE: rate_reg = val;
      REG_FRAMES: frames_reg = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (word_queue.size() != 0 || in_valid || byte_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] b;
    case ($urandom_range(5, 0))
      0: b = $urandom();
      1: b = {$urandom_range(1, 0) == 1, 8'($urandom_range(127, 100)), 23'($urandom())};
      2: b = {$urandom_range(1, 0) == 1, 8'($urandom_range(126, 0)), 23'($urandom())};
      3: b = {$urandom_range(1, 0) == 1, 8'hFF, 23'($urandom())};
      4: b = {$urandom_range(1, 0) == 1, 8'd127, 23'($urandom_range(3, 0))};
      default: b = $shortrealtobits(shortreal'($urandom_range(65535, 0)) / 65535.0
                                   * 2.0 - 1.0);
    endcase
    return b;
  endfunction

  task automatic add_word(input logic c, input logic [31:0] s);
    word_queue.insert(word_queue.size(), '{cmd: c, sample_bits: s});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: header at reset values, sample extremes and halfway points.
    add_word(CMD_HEADER, 32'hFFFFFFFF);
    add_word(CMD_SAMPLE, 32'h3F800000);
    add_word(CMD_SAMPLE, 32'hBF800000);
    add_word(CMD_SAMPLE, 32'h40000000);
    add_word(CMD_SAMPLE, 32'hC0000000);
    add_word(CMD_SAMPLE, 32'h00000000);
    add_word(CMD_SAMPLE, 32'h80000000);
    add_word(CMD_SAMPLE, 32'h7F800000);
    add_word(CMD_SAMPLE, 32'hFF800000);
    add_word(CMD_SAMPLE, 32'h7FC00001);
    add_word(CMD_SAMPLE, 32'hFFFFFFFF);
    add_word(CMD_SAMPLE, 32'h00000001);
    add_word(CMD_SAMPLE, 32'h38000000);
    add_word(CMD_SAMPLE, 32'hB8000000);
    add_word(CMD_SAMPLE, 32'h7F7FFFFF);
    add_word(CMD_SAMPLE, 32'h3F000000);
    add_word(CMD_SAMPLE, 32'hBF000000);
    wait_drained();
    // Zero registers take their defaults.
    reg_write(REG_CHANNELS, 32'd0);
    reg_write(REG_RATE, 32'd0);
    reg_write(REG_FRAMES, 32'hFFFFFFFF);
    add_word(CMD_HEADER, 32'd0);
    wait_drained();
    reg_write(REG_CHANNELS, 32'h0000FFFF);
    reg_write(REG_RATE, 32'hFFFFFFFF);
    reg_write(REG_FRAMES, 32'h12345678);
    add_word(CMD_HEADER, 32'h0);
    wait_drained();
    // Random phases: new settings, a header, then samples with an occasional header.
    for (int ph = 0; ph < 10; ph++) begin
      reg_write(REG_CHANNELS, $urandom_range(1, 0) ? $urandom_range(8, 1) : $urandom());
      reg_write(REG_RATE, $urandom_range(1, 0) ? 32'd48000 : $urandom());
      reg_write(REG_FRAMES, $urandom());
      add_word(CMD_HEADER, $urandom());
      for (int i = 0; i < 23; i++) begin
        if ($urandom_range(30, 0) == 0) add_word(CMD_HEADER, $urandom());
        else add_word(CMD_SAMPLE, random_float());
      end
      wait_drained();
    end
    $display("covered %0d headers and %0d samples, %0d bytes checked",
             headers_sent, samples_sent, bytes_seen);
    if (mismatches == 0 && byte_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d bytes still expected", mismatches, byte_queue.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
